// File: hdl/ssed_pkg.sv
package ssed_pkg;

    // Field and register widths
    localparam int GREY_W         = 8;
    localparam int BYTE_W         = 8;
    localparam int LINE_WIDTH_W   = 12;
    localparam int THRESH_W       = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 2;
    localparam int GRAD_MODE_W    = 2;
    localparam int EDGE_W         = 8;

    // Gradient arithmetic: |G| <= 4080 for Scharr, so 13 signed bits hold it
    localparam int GRAD_W         = 13;
    localparam int ABS_W          = GRAD_W - 1;
    localparam int SQ_W           = 2 * ABS_W;
    localparam int THR_SQ_W       = 2 * THRESH_W;

    // Luma weights, 0.2126 / 0.7152 / 0.0722 scaled by 65536
    localparam int WEIGHT_W       = 16;
    localparam int GREY_SUM_W     = WEIGHT_W + BYTE_W;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FIRST  = 16'd13933;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SECOND = 16'd46871;
    localparam logic [WEIGHT_W-1:0] WEIGHT_THIRD  = 16'd4732;

    localparam int KERNEL_SIZE            = 3;
    localparam int MAX_LINE_WIDTH_DEFAULT = 2048;
    localparam int QUEUE_DEPTH            = 4;

    localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

    // Register reset values
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET     = 12'd640;
    localparam logic                    KERNEL_KIND_RESET    = 1'b0;
    localparam logic [GRAD_MODE_W-1:0]  GRADIENT_MODE_RESET  = 2'd2;
    localparam logic [THRESH_W-1:0]     EDGE_THRESHOLD_RESET = 13'd60;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_WIDTH     = 2'd0,
        CFG_KERNEL_KIND    = 2'd1,
        CFG_GRADIENT_MODE  = 2'd2,
        CFG_EDGE_THRESHOLD = 2'd3
    } cfg_index_t;

    localparam logic KERNEL_SOBEL  = 1'b0;
    localparam logic KERNEL_SCHARR = 1'b1;

    localparam logic [GRAD_MODE_W-1:0] GRAD_MODE_X   = 2'd0;
    localparam logic [GRAD_MODE_W-1:0] GRAD_MODE_Y   = 2'd1;
    localparam logic [GRAD_MODE_W-1:0] GRAD_MODE_MAG = 2'd2;

    // Settings the back end needs
    typedef struct packed {
        logic                   kernel_kind;
        logic [GRAD_MODE_W-1:0] gradient_mode;
        logic [THRESH_W-1:0]    edge_threshold;
    } cfg_t;

endpackage

// File: hdl/sobel_scharr_edge_threshold_unit.sv
// 3x3 Sobel / Scharr edge detector with threshold, one pixel per item.
//
// Input channel (in_valid / in_stall): one three-byte pixel per item in
// raster order; frame_start marks the first pixel of a frame and clears the
// row and column counts. Output channel (out_valid / out_stall): one item per
// input item, in order: edge_value is 255 or 0 for the window centre, which
// lies one row up and one column left of the pixel just taken; window_valid
// is 1 once the 3x3 window sits fully inside the image.
// Throughput: one item per clock unless the receiver stalls, set by the line
// store access in the back end: each store takes one read and one write-back
// per pixel in the same cycle, with forwarding when consecutive pixels hit
// the same column. An item goes through the queue, stages 2-4 and out_valid_reg.
// The front end converts to grey, tracks row and column and pushes into a
// four-entry queue; in_stall rises only when that queue is full. When the
// receiver stalls, the back pipeline holds and the queue fills.
// Reset clears the counts, the window and all pipeline valids, and loads the
// register defaults (width 640, Sobel, magnitude, threshold 60). The line
// stores are not cleared; they fill as the first two lines stream in.
// Write configuration over cfg_we / cfg_index / cfg_data only while idle.
module sobel_scharr_edge_threshold_unit #(
    parameter int MAX_LINE_WIDTH = ssed_pkg::MAX_LINE_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ssed_pkg::BYTE_W-1:0]      first_byte,
    input  logic [ssed_pkg::BYTE_W-1:0]      second_byte,
    input  logic [ssed_pkg::BYTE_W-1:0]      third_byte,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ssed_pkg::EDGE_W-1:0]      edge_value,
    output logic                             window_valid,
    input  logic                             cfg_we,
    input  logic [ssed_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssed_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssed_pkg::*;

    localparam int CW     = $clog2(MAX_LINE_WIDTH);
    localparam int ITEM_W = 1 + GREY_W + CW;

    // Configuration registers
    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic                    kernel_kind_reg;
    logic [GRAD_MODE_W-1:0]  gradient_mode_reg;
    logic [THRESH_W-1:0]     edge_threshold_reg;
    cfg_t                    back_cfg;

    // Front to queue to back
    logic                    q_push, q_full, q_pop, q_head_valid;
    logic [ITEM_W-1:0]       q_push_item, q_head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg     <= LINE_WIDTH_RESET;
            kernel_kind_reg    <= KERNEL_KIND_RESET;
            gradient_mode_reg  <= GRADIENT_MODE_RESET;
            edge_threshold_reg <= EDGE_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LINE_WIDTH:
                begin
                    line_width_reg <= cfg_data[LINE_WIDTH_W-1:0];
                end
                CFG_KERNEL_KIND:
                begin
                    kernel_kind_reg <= cfg_data[0];
                end
                CFG_GRADIENT_MODE:
                begin
                    gradient_mode_reg <= cfg_data[GRAD_MODE_W-1:0];
                end
                CFG_EDGE_THRESHOLD:
                begin
                    edge_threshold_reg <= cfg_data[THRESH_W-1:0];
                end
                default:
                begin
                    line_width_reg <= line_width_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        back_cfg.kernel_kind    = kernel_kind_reg;
        back_cfg.gradient_mode  = gradient_mode_reg;
        back_cfg.edge_threshold = edge_threshold_reg;
    end

    // Accept, convert to grey and tag each pixel with its column and window state
    ssed_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .frame_start (frame_start),
        .line_width  (line_width_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    // Decouple the two halves so each may stall on its own
    ssed_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    // Line stores, window, gradients, threshold and the output register
    ssed_back #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_item    (q_head_item),
        .pop          (q_pop),
        .cfg          (back_cfg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_value   (edge_value),
        .window_valid (window_valid)
    );

endmodule

// File: hdl/ssed_queue.sv
module ssed_queue #(
    parameter int DATA_W = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_item,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_item
);
    import ssed_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

endmodule

// File: hdl/ssed_front.sv
module ssed_front #(
    parameter int MAX_LINE_WIDTH = ssed_pkg::MAX_LINE_WIDTH_DEFAULT,
    localparam int CW     = $clog2(MAX_LINE_WIDTH),
    localparam int ITEM_W = 1 + ssed_pkg::GREY_W + CW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ssed_pkg::BYTE_W-1:0]       first_byte,
    input  logic [ssed_pkg::BYTE_W-1:0]       second_byte,
    input  logic [ssed_pkg::BYTE_W-1:0]       third_byte,
    input  logic                              frame_start,
    input  logic [ssed_pkg::LINE_WIDTH_W-1:0] line_width,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [ITEM_W-1:0]                 q_item
);
    import ssed_pkg::*;

    localparam int CMP_W = ((CW + 1) > LINE_WIDTH_W) ? (CW + 1) : LINE_WIDTH_W;

    logic [CW-1:0]         col_reg, col_next, col_cur;
    logic [1:0]            row_reg, row_next, row_cur;
    logic [CMP_W-1:0]      width_eff, col_inc;
    logic [GREY_SUM_W-1:0] grey_sum;
    logic                  win_valid;
    logic                  accept;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign q_push   = accept;

    // Clamp the line width between the kernel size and what the line stores hold
    always_comb
    begin
        if (CMP_W'(line_width) < CMP_W'(KERNEL_SIZE))
        begin
            width_eff = CMP_W'(KERNEL_SIZE);
        end
        else if (CMP_W'(line_width) > CMP_W'(MAX_LINE_WIDTH))
        begin
            width_eff = CMP_W'(MAX_LINE_WIDTH);
        end
        else
        begin
            width_eff = CMP_W'(line_width);
        end
    end

    always_comb
    begin
        col_cur   = frame_start ? '0 : col_reg;
        row_cur   = frame_start ? '0 : row_reg;
        win_valid = (row_cur >= 2'(KERNEL_SIZE - 1))
                 && (CMP_W'(col_cur) >= CMP_W'(KERNEL_SIZE - 1));
        col_inc   = CMP_W'(col_cur) + 1'b1;
        row_next  = row_cur;
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            if (row_cur < 2'(KERNEL_SIZE - 1))
            begin
                row_next = row_cur + 1'b1;
            end
        end
        else
        begin
            col_next = col_inc[CW-1:0];
        end
    end

    always_comb
    begin
        grey_sum = GREY_SUM_W'(WEIGHT_FIRST * GREY_SUM_W'(first_byte))
                 + GREY_SUM_W'(WEIGHT_SECOND * GREY_SUM_W'(second_byte))
                 + GREY_SUM_W'(WEIGHT_THIRD * GREY_SUM_W'(third_byte));
    end

    assign q_item = {win_valid, grey_sum[GREY_SUM_W-1 -: GREY_W], col_cur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: hdl/ssed_back.sv
module ssed_back #(
    parameter int MAX_LINE_WIDTH = ssed_pkg::MAX_LINE_WIDTH_DEFAULT,
    localparam int CW     = $clog2(MAX_LINE_WIDTH),
    localparam int ITEM_W = 1 + ssed_pkg::GREY_W + CW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  logic [ITEM_W-1:0]           head_item,
    output logic                        pop,
    input  ssed_pkg::cfg_t              cfg,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ssed_pkg::EDGE_W-1:0] edge_value,
    output logic                        window_valid
);
    import ssed_pkg::*;

    localparam int COL_W = 3 * GREY_W;

    logic                 adv;
    logic [CW-1:0]        head_idx;
    logic [GREY_W-1:0]    head_grey;
    logic                 head_win;

    logic [GREY_W-1:0]    upper_mem  [MAX_LINE_WIDTH];
    logic [GREY_W-1:0]    middle_mem [MAX_LINE_WIDTH];
    logic [GREY_W-1:0]    upper_rd_reg, middle_rd_reg;

    // Stage 2: line store read data, forwarding, window
    logic                 p2_valid_reg, p2_win_reg, p2_fwd_reg;
    logic [CW-1:0]        p2_idx_reg;
    logic [GREY_W-1:0]    p2_grey_reg, fwd_upper_reg, fwd_middle_reg;
    logic [GREY_W-1:0]    upper_eff, middle_eff;
    logic [COL_W-1:0]     win0_reg, win1_reg, cur_col;
    logic signed [GRAD_W-1:0] gx, gy;

    // Stage 3: gradients
    logic                 p3_valid_reg, p3_win_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [ABS_W-1:0]     abs_x, abs_y;

    // Stage 4: magnitudes and squares
    logic                 p4_valid_reg, p4_win_reg;
    logic [ABS_W-1:0]     abs_x_reg, abs_y_reg;
    logic [SQ_W-1:0]      sq_x_reg, sq_y_reg;
    logic [THR_SQ_W-1:0]  thr_sq_reg, mag_sum;
    logic                 edge_hit;

    logic                 out_valid_reg, window_valid_reg;
    logic [EDGE_W-1:0]    edge_value_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = adv && head_valid;
    assign head_idx  = head_item[CW-1:0];
    assign head_grey = head_item[CW +: GREY_W];
    assign head_win  = head_item[ITEM_W-1];

    function automatic logic signed [GRAD_W-1:0] diff(input logic [GREY_W-1:0] a,
                                                      input logic [GREY_W-1:0] b);
        return $signed(GRAD_W'(a)) - $signed(GRAD_W'(b));
    endfunction

    function automatic logic signed [GRAD_W-1:0] side_wt(input logic k,
                                                         input logic signed [GRAD_W-1:0] d);
        return (k == KERNEL_SCHARR) ? d + (d <<< 1) : d;
    endfunction

    function automatic logic signed [GRAD_W-1:0] centre_wt(input logic k,
                                                           input logic signed [GRAD_W-1:0] d);
        return (k == KERNEL_SCHARR) ? (d <<< 3) + (d <<< 1) : (d <<< 1);
    endfunction

    // Line stores: read at the head item, write back the item in stage 2
    always_ff @(posedge clk)
    begin
        if (adv && p2_valid_reg)
        begin
            upper_mem[p2_idx_reg] <= middle_eff;
        end
        if (pop)
        begin
            upper_rd_reg <= upper_mem[head_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && p2_valid_reg)
        begin
            middle_mem[p2_idx_reg] <= p2_grey_reg;
        end
        if (pop)
        begin
            middle_rd_reg <= middle_mem[head_idx];
        end
    end

    // Forward the stage 2 write when the next item reads the same column
    assign upper_eff  = p2_fwd_reg ? fwd_upper_reg  : upper_rd_reg;
    assign middle_eff = p2_fwd_reg ? fwd_middle_reg : middle_rd_reg;
    assign cur_col    = {upper_eff, middle_eff, p2_grey_reg};

    always_comb
    begin
        gx = side_wt(cfg.kernel_kind, diff(win1_reg[23:16], cur_col[23:16]))
           + centre_wt(cfg.kernel_kind, diff(win1_reg[15:8], cur_col[15:8]))
           + side_wt(cfg.kernel_kind, diff(win1_reg[7:0], cur_col[7:0]));
        gy = side_wt(cfg.kernel_kind, diff(win1_reg[23:16], win1_reg[7:0]))
           + centre_wt(cfg.kernel_kind, diff(win0_reg[23:16], win0_reg[7:0]))
           + side_wt(cfg.kernel_kind, diff(cur_col[23:16], cur_col[7:0]));
    end

    assign abs_x = gx_reg[GRAD_W-1] ? ABS_W'(-gx_reg) : ABS_W'(gx_reg);
    assign abs_y = gy_reg[GRAD_W-1] ? ABS_W'(-gy_reg) : ABS_W'(gy_reg);

    assign mag_sum = THR_SQ_W'(sq_x_reg) + THR_SQ_W'(sq_y_reg);

    always_comb
    begin
        unique case (cfg.gradient_mode)
            GRAD_MODE_X:
            begin
                edge_hit = THRESH_W'(abs_x_reg) >= cfg.edge_threshold;
            end
            GRAD_MODE_Y:
            begin
                edge_hit = THRESH_W'(abs_y_reg) >= cfg.edge_threshold;
            end
            default:
            begin
                edge_hit = mag_sum >= thr_sq_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win0_reg      <= '0;
            win1_reg      <= '0;
        end
        else if (adv)
        begin
            p2_valid_reg  <= head_valid;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= p4_valid_reg;
            if (p2_valid_reg)
            begin
                win1_reg <= win0_reg;
                win0_reg <= cur_col;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        thr_sq_reg <= THR_SQ_W'(cfg.edge_threshold) * THR_SQ_W'(cfg.edge_threshold);
        if (adv)
        begin
            p2_idx_reg     <= head_idx;
            p2_grey_reg    <= head_grey;
            p2_win_reg     <= head_win;
            p2_fwd_reg     <= p2_valid_reg && (head_idx == p2_idx_reg);
            fwd_upper_reg  <= middle_eff;
            fwd_middle_reg <= p2_grey_reg;

            gx_reg     <= gx;
            gy_reg     <= gy;
            p3_win_reg <= p2_win_reg;

            abs_x_reg  <= abs_x;
            abs_y_reg  <= abs_y;
            sq_x_reg   <= SQ_W'(abs_x) * SQ_W'(abs_x);
            sq_y_reg   <= SQ_W'(abs_y) * SQ_W'(abs_y);
            p4_win_reg <= p3_win_reg;

            window_valid_reg <= p4_win_reg;
            edge_value_reg   <= (p4_win_reg && edge_hit) ? EDGE_ON : EDGE_OFF;
        end
    end

    assign out_valid    = out_valid_reg;
    assign edge_value   = edge_value_reg;
    assign window_valid = window_valid_reg;

endmodule
